// ===== rtl/disk_chs_geometry_defines.svh =====
// ----------------------------------------------------------------------------
// disk_chs_geometry_defines
// Assertion macros used by the disk geometry RTL.
// ----------------------------------------------------------------------------
`ifndef DISK_CHS_GEOMETRY_DEFINES_SVH
`define DISK_CHS_GEOMETRY_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DCG_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("disk_chs_geometry: assertion failed");
`define DCG_ASSERT_IMPL(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("disk_chs_geometry: assertion failed");
`else
`define DCG_ASSERT(name, clk, rst_n, prop)
`define DCG_ASSERT_IMPL(name, clk, rst_n, pre, post)
`endif

`endif

// ===== rtl/dcg_pkg.sv =====
// ----------------------------------------------------------------------------
// dcg_pkg
// Widths, limits and reciprocal constants of the disk geometry pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcg_pkg;

  localparam int unsigned TotalW        = 48;
  localparam int unsigned SatW          = 28;
  localparam int unsigned QuotW         = 24;
  localparam int unsigned ChW           = 20;
  localparam int unsigned RecipW        = 32;
  localparam int unsigned RecipShift    = 36;
  localparam int unsigned ProdW         = SatW + RecipW;
  localparam int unsigned SpanW         = 10;
  localparam int unsigned SptW          = 8;
  localparam int unsigned HeadW         = 5;
  localparam int unsigned CylW          = 16;
  localparam int unsigned HeadRecipW    = 19;
  localparam int unsigned HeadRecipShift = 20;
  localparam int unsigned HeadProdW     = ChW + HeadRecipW;

  localparam logic [TotalW-1:0] SatLimit   = TotalW'(64'd65535 * 64'd16 * 64'd255);
  localparam logic [SatW-1:0]   LargeLimit = SatW'(64'd65535 * 64'd16 * 64'd63);

  localparam logic [SptW-1:0] Spt17  = 8'd17;
  localparam logic [SptW-1:0] Spt31  = 8'd31;
  localparam logic [SptW-1:0] Spt63  = 8'd63;
  localparam logic [SptW-1:0] Spt255 = 8'd255;

  localparam logic [HeadW-1:0] HeadsMin = 5'd4;
  localparam logic [HeadW-1:0] HeadsMax = 5'd16;

  localparam logic [QuotW:0]   TrackRound   = (QuotW+1)'((64'd1 << SpanW) - 64'd1);
  localparam logic [QuotW-1:0] MaxCylHeads  = QuotW'(64'd16 << SpanW);

  localparam logic [RecipW-1:0] Recip17  =
    RecipW'(((64'd1 << RecipShift) + 64'd16) / 64'd17);
  localparam logic [RecipW-1:0] Recip31  =
    RecipW'(((64'd1 << RecipShift) + 64'd30) / 64'd31);
  localparam logic [RecipW-1:0] Recip63  =
    RecipW'(((64'd1 << RecipShift) + 64'd62) / 64'd63);
  localparam logic [RecipW-1:0] Recip255 =
    RecipW'(((64'd1 << RecipShift) + 64'd254) / 64'd255);

  // ceil(2^20 / heads)
  function automatic logic [HeadRecipW-1:0] head_recip(input logic [HeadW-1:0] heads);
    logic [HeadRecipW-1:0] r;
    case (heads)
      5'd4:    r = 19'd262144;
      5'd5:    r = 19'd209716;
      5'd6:    r = 19'd174763;
      5'd7:    r = 19'd149797;
      5'd8:    r = 19'd131072;
      5'd9:    r = 19'd116509;
      5'd10:   r = 19'd104858;
      5'd11:   r = 19'd95326;
      5'd12:   r = 19'd87382;
      5'd13:   r = 19'd80660;
      5'd14:   r = 19'd74899;
      5'd15:   r = 19'd69906;
      default: r = 19'd65536;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/disk_chs_geometry.sv =====
// ----------------------------------------------------------------------------
// disk_chs_geometry
// Virtual-disk cylinder/head/sector geometry from a total sector count.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: drive total_sectors_i and raise start; the beat is taken at
//   a rising edge with start high and busy low. busy stays low, so a new
//   beat may enter every cycle.
//   Result beat: done_o is high for one cycle with sectors_per_track_o,
//   head_count_o and cylinder_count_o; the receiver must take it then.
//   Order: results are shown in the same order as the input beats.
//   Throughput: one beat per cycle through the five-stage pipeline:
//   saturate, reciprocal multiplies for 17/31/63/255, track selection,
//   head reciprocal multiply, output register.
//   Reset: clears the stage valid bits, so no result is shown until a new
//   beat has passed the pipeline. The receiver cannot stall, so the
//   pipeline never holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "disk_chs_geometry_defines.svh"

module disk_chs_geometry (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [dcg_pkg::TotalW-1:0]   total_sectors_i,
  output logic                         done_o,
  output logic [dcg_pkg::SptW-1:0]     sectors_per_track_o,
  output logic [dcg_pkg::HeadW-1:0]    head_count_o,
  output logic [dcg_pkg::CylW-1:0]     cylinder_count_o
);

  import dcg_pkg::*;

  logic                  accept;
  logic [SatW-1:0]       sat_total;

  logic                  v1_q;
  logic [SatW-1:0]       total1_q;

  logic                  v2_q;
  logic                  large2_q;
  logic [ProdW-1:0]      prod17_q, prod31_q, prod63_q, prod255_q;

  logic [QuotW-1:0]      q17, q31, q63, q255;
  logic [QuotW:0]        round17;
  logic [HeadW-1:0]      heads_ceil, heads_clamp;
  logic                  fits17, fits31;
  logic [SptW-1:0]       spt3_d;
  logic [HeadW-1:0]      heads3_d;
  logic [ChW-1:0]        ch3_d;

  logic                  v3_q;
  logic [SptW-1:0]       spt3_q;
  logic [HeadW-1:0]      heads3_q;
  logic [ChW-1:0]        ch3_q;

  logic                  v4_q;
  logic [SptW-1:0]       spt4_q;
  logic [HeadW-1:0]      heads4_q;
  logic [HeadProdW-1:0]  prod4_q;

  logic                  done_q;
  logic [SptW-1:0]       spt_q;
  logic [HeadW-1:0]      heads_q;
  logic [CylW-1:0]       cyl_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign sat_total = (total_sectors_i > SatLimit) ? SatLimit[SatW-1:0]
                                                  : total_sectors_i[SatW-1:0];

  // track selection
  always_comb begin
    q17  = prod17_q[RecipShift +: QuotW];
    q31  = prod31_q[RecipShift +: QuotW];
    q63  = prod63_q[RecipShift +: QuotW];
    q255 = prod255_q[RecipShift +: QuotW];

    round17     = {1'b0, q17} + TrackRound;
    heads_ceil  = round17[SpanW +: HeadW];
    heads_clamp = (heads_ceil < HeadsMin) ? HeadsMin : heads_ceil;

    fits17 = (q17 <= MaxCylHeads) &&
             (q17[SpanW+HeadW-1:0] < {heads_clamp, {SpanW{1'b0}}});
    fits31 = (q31 < MaxCylHeads);

    if (large2_q) begin
      spt3_d   = Spt255;
      heads3_d = HeadsMax;
      ch3_d    = q255[ChW-1:0];
    end else if (fits17) begin
      spt3_d   = Spt17;
      heads3_d = heads_clamp;
      ch3_d    = q17[ChW-1:0];
    end else if (fits31) begin
      spt3_d   = Spt31;
      heads3_d = HeadsMax;
      ch3_d    = q31[ChW-1:0];
    end else begin
      spt3_d   = Spt63;
      heads3_d = HeadsMax;
      ch3_d    = q63[ChW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= accept;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      done_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    total1_q  <= sat_total;

    large2_q  <= (total1_q >= LargeLimit);
    prod17_q  <= ProdW'(total1_q) * ProdW'(Recip17);
    prod31_q  <= ProdW'(total1_q) * ProdW'(Recip31);
    prod63_q  <= ProdW'(total1_q) * ProdW'(Recip63);
    prod255_q <= ProdW'(total1_q) * ProdW'(Recip255);

    spt3_q    <= spt3_d;
    heads3_q  <= heads3_d;
    ch3_q     <= ch3_d;

    spt4_q    <= spt3_q;
    heads4_q  <= heads3_q;
    prod4_q   <= HeadProdW'(ch3_q) * HeadProdW'(head_recip(heads3_q));

    spt_q     <= spt4_q;
    heads_q   <= heads4_q;
    cyl_q     <= prod4_q[HeadRecipShift +: CylW];
  end

  assign done_o              = done_q;
  assign sectors_per_track_o = spt_q;
  assign head_count_o        = heads_q;
  assign cylinder_count_o    = cyl_q;

  `DCG_ASSERT_IMPL(a_latency, clk_i, rst_ni, start && !busy, ##5 done_o)
  `DCG_ASSERT_IMPL(a_spt_legal, clk_i, rst_ni, done_o,
    sectors_per_track_o == Spt17 || sectors_per_track_o == Spt31 ||
    sectors_per_track_o == Spt63 || sectors_per_track_o == Spt255)
  `DCG_ASSERT_IMPL(a_heads_full, clk_i, rst_ni,
    done_o && sectors_per_track_o != Spt17, head_count_o == HeadsMax)
  `DCG_ASSERT_IMPL(a_heads_range, clk_i, rst_ni, done_o,
    head_count_o >= HeadsMin && head_count_o <= HeadsMax)

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the disk CHS geometry pipeline.
// ----------------------------------------------------------------------------
// Sector counts enter as start/busy beats with random gaps, plus one stretch
// with no gaps. They cover the corners of each geometry region, both
// saturation points and the full 48-bit range. Every count is predicted
// into sectors per track, heads and cylinders. Each done_o beat is checked
// in order against the oldest prediction. A watchdog ends a run that
// stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import dcg_pkg::*;

  localparam int unsigned MaxSectors  = 65535 * 16 * 255;
  localparam int unsigned WideSectors = 65535 * 16 * 63;
  localparam int unsigned TrackSpan   = 1024;
  localparam int unsigned RandomBeats = 1200;
  localparam int unsigned QuietLimit  = 1000;
  localparam int unsigned DrainCycles = 12;

  typedef struct packed {
    logic [SptW-1:0]  spt;
    logic [HeadW-1:0] heads;
    logic [CylW-1:0]  cyls;
  } chs_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [TotalW-1:0]   total_sectors_i;
  logic                done_o;
  logic [SptW-1:0]     sectors_per_track_o;
  logic [HeadW-1:0]    head_count_o;
  logic [CylW-1:0]     cylinder_count_o;

  logic                gaps_on;
  int unsigned         quiet_cycles;

  function automatic chs_t chs_for_count(input logic [TotalW-1:0] count);
    logic [63:0] n;
    logic [31:0] per_cyl;
    logic [31:0] heads;
    logic [7:0]  spt;
    chs_t        g;
    n = 64'(count);
    if (n > 64'(MaxSectors)) n = 64'(MaxSectors);
    if (n >= 64'(WideSectors)) begin
      spt     = Spt255;
      heads   = 32'(HeadsMax);
      per_cyl = 32'(n / 64'(Spt255));
    end else begin
      spt     = Spt17;
      per_cyl = 32'(n / 64'(Spt17));
      heads   = (per_cyl + TrackSpan - 1) / TrackSpan;
      if (heads < 32'(HeadsMin)) heads = 32'(HeadsMin);
      if (per_cyl >= heads * TrackSpan || heads > 32'(HeadsMax)) begin
        spt     = Spt31;
        heads   = 32'(HeadsMax);
        per_cyl = 32'(n / 64'(Spt31));
      end
      if (per_cyl >= heads * TrackSpan) begin
        spt     = Spt63;
        heads   = 32'(HeadsMax);
        per_cyl = 32'(n / 64'(Spt63));
      end
    end
    g.spt   = spt;
    g.heads = heads[HeadW-1:0];
    g.cyls  = 16'(per_cyl / heads);
    return g;
  endfunction

  class chs_scoreboard;
    chs_t        geometry_q[$];
    int unsigned errors = 0;

    function void note_sectors(input logic [TotalW-1:0] count);
      geometry_q.push_back(chs_for_count(count));
    endfunction

    function void check_geometry(input logic [SptW-1:0] spt, input logic [HeadW-1:0] heads,
                                 input logic [CylW-1:0] cyls);
      chs_t want;
      if (geometry_q.size() == 0) begin
        $error("unexpected geometry beat: spt %0d heads %0d cylinders %0d", spt, heads, cyls);
        errors++;
        return;
      end
      want = geometry_q.pop_front();
      if (spt !== want.spt) begin
        $error("sectors_per_track: expected %0d, actual %0d", want.spt, spt);
        errors++;
      end
      if (heads !== want.heads) begin
        $error("head_count: expected %0d, actual %0d", want.heads, heads);
        errors++;
      end
      if (cyls !== want.cyls) begin
        $error("cylinder_count: expected %0d, actual %0d", want.cyls, cyls);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return geometry_q.size();
    endfunction
  endclass

  chs_scoreboard geo_sb;

  logic [TotalW-1:0] corner_counts [23] = '{
    48'd0, 48'd1, 48'd17, 48'd69631, 48'd69632, 48'd69649, 48'd87040,
    48'd278527, 48'd278528, 48'd507903, 48'd507904, 48'd1032191, 48'd1032192,
    48'(WideSectors - 1), 48'(WideSectors), 48'(MaxSectors - 1), 48'(MaxSectors),
    48'(MaxSectors + 1), 48'hFFFF_FFFF_FFFF, 48'hAAAA_AAAA_AAAA,
    48'h5555_5555_5555, 48'h8000_0000_0000, 48'h0000_FFFF_FFFF
  };

  disk_chs_geometry uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .total_sectors_i     (total_sectors_i),
    .done_o              (done_o),
    .sectors_per_track_o (sectors_per_track_o),
    .head_count_o        (head_count_o),
    .cylinder_count_o    (cylinder_count_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [TotalW-1:0] pick_sectors();
    longint pick;
    int     offset;
    pick   = 0;
    offset = 0;
    case ($urandom_range(9))
      0: return {16'($urandom), $urandom};
      1: pick = $urandom_range(MaxSectors);
      2: pick = $urandom_range(WideSectors - 1);
      3: pick = $urandom_range(17 * 4 * TrackSpan * 2);
      4: begin
        pick   = longint'($urandom_range(17)) * 17 * TrackSpan;
        offset = int'($urandom_range(80)) - 40;
      end
      5: begin
        pick   = 31 * 16 * TrackSpan;
        offset = int'($urandom_range(128)) - 64;
      end
      6: begin
        pick   = 63 * 16 * TrackSpan;
        offset = int'($urandom_range(128)) - 64;
      end
      7: begin
        pick   = WideSectors;
        offset = int'($urandom_range(600)) - 300;
      end
      8: begin
        pick   = MaxSectors;
        offset = int'($urandom_range(600)) - 300;
      end
      default: pick = longint'($urandom) << $urandom_range(16);
    endcase
    pick = pick + offset;
    if (pick < 0) pick = 0;
    return TotalW'(pick);
  endfunction

  task automatic send_sectors(input logic [TotalW-1:0] count);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < 25) begin
      start           <= 1'b0;
      total_sectors_i <= {16'($urandom), $urandom};
      @(negedge clk_i);
    end
    start           <= 1'b1;
    total_sectors_i <= count;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    geo_sb.note_sectors(count);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      geo_sb.check_geometry(sectors_per_track_o, head_count_o, cylinder_count_o);
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    geo_sb          = new();
    rst_ni          = 1'b0;
    start           = 1'b0;
    total_sectors_i = '0;
    gaps_on         = 1'b1;
    quiet_cycles    = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (corner_counts[i]) send_sectors(corner_counts[i]);

    for (int unsigned n = 0; n < RandomBeats; n++) begin
      gaps_on = !(n >= 400 && n < 700);
      send_sectors(pick_sectors());
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (geo_sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (geo_sb.errors == 0 && geo_sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dcg_pkg.sv
rtl/disk_chs_geometry.sv
tb/sv/tb_top.sv
